FILE: hdl/tcce_pkg.sv
package tcce_pkg;

    // Cell store geometry. The stored dimensions are powers of two, so a cell
    // address is the row number over the column number.
    localparam int STORED_ROWS = 32;
    localparam int STORED_COLS = 128;
    localparam int TEXT_ROWS   = 30;
    localparam int TEXT_COLS   = 80;

    localparam int CELL_COUNT = STORED_ROWS * STORED_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COL_SH     = $clog2(STORED_COLS);

    // Field widths of the request and result payloads.
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 12;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int RATE_W   = 8;
    localparam int CURSOR_W = 24;
    localparam int CELL_W   = 32;

    // Newline on this row scrolls the text area instead of moving down.
    localparam int SCROLL_ROW   = TEXT_ROWS - 2;
    localparam int SCROLL_CELLS = SCROLL_ROW * STORED_COLS;

    // Tab stops fall on multiples of this width.
    localparam int TAB_STOP = 4;
    localparam int TAB_AW   = $clog2(TAB_STOP);

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CELL_W-1:0] BLANK_CELL = 32'h000f_ff00;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Control characters.
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0d;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [ROW_W-1:0]   clear_rows;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]    cursor_row_out;
        logic [COL_W-1:0]    cursor_col_out;
        logic [CURSOR_W-1:0] cursor_word;
        logic [CELL_W-1:0]   cell_word;
    } out_t;

    // Operation classes that the front hands to the back.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUTC,
        OP_NEWLINE,
        OP_TAB,
        OP_CLEAR,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [ROW_W-1:0]   clear_rows;
        addr_t              read_addr;
    } op_t;

    // Address of the cell at a row and column, both wrapped to the store.
    function automatic addr_t cell_addr(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        addr_t r_part;
        addr_t c_part;
        r_part = ADDR_W'((row % STORED_ROWS) * STORED_COLS);
        c_part = ADDR_W'(col % STORED_COLS);
        return r_part + c_part;
    endfunction

endpackage

FILE: hdl/tcce_front.sv
module tcce_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  tcce_pkg::in_t  in_data,
    input  logic           init_busy,
    output logic           push_valid,
    input  logic           push_ready,
    output tcce_pkg::op_t  push_op
);

    logic          op_valid_reg;
    logic          op_valid_next;
    tcce_pkg::op_t op_reg;
    tcce_pkg::op_t op_next;
    logic          accept;
    logic          push;

    // Sort a request into the operation class that the back carries out.
    function automatic tcce_pkg::op_kind_t classify(input tcce_pkg::in_t req);
        tcce_pkg::op_kind_t kind;
        kind = tcce_pkg::OP_NOP;
        priority if (req.cmd == tcce_pkg::CMD_PUT)
        begin
            priority if (req.char_code == tcce_pkg::CHAR_CR)
                kind = tcce_pkg::OP_NOP;
            else if (req.char_code == tcce_pkg::CHAR_LF)
                kind = tcce_pkg::OP_NEWLINE;
            else if (req.char_code == tcce_pkg::CHAR_TAB)
                kind = tcce_pkg::OP_TAB;
            else
                kind = tcce_pkg::OP_PUTC;
        end
        else if (req.cmd == tcce_pkg::CMD_CLEAR)
            kind = tcce_pkg::OP_CLEAR;
        else if (req.cmd == tcce_pkg::CMD_READ)
            kind = tcce_pkg::OP_READ;
        else
            kind = tcce_pkg::OP_NOP;
        return kind;
    endfunction

    // The holding register frees up whenever its operation enters the queue.
    assign push       = op_valid_reg && push_ready;
    assign in_stall   = init_busy || (op_valid_reg && !push_ready);
    assign accept     = in_valid && !in_stall;
    assign push_valid = op_valid_reg;
    assign push_op    = op_reg;

    // Build the operation record for an accepted request.
    always_comb
    begin
        op_valid_next = op_valid_reg;
        op_next       = op_reg;
        if (push)
        begin
            op_valid_next = 1'b0;
        end
        if (accept)
        begin
            op_valid_next     = 1'b1;
            op_next.kind       = classify(in_data);
            op_next.char_code  = in_data.char_code;
            op_next.fg_color   = in_data.fg_color;
            op_next.bg_color   = in_data.bg_color;
            op_next.clear_rows = in_data.clear_rows;
            op_next.read_addr  = tcce_pkg::cell_addr(in_data.read_row, in_data.read_col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    // The operation payload needs no reset.
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

endmodule

FILE: hdl/tcce_queue.sv
module tcce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tcce_pkg::op_t  push_op,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tcce_pkg::op_t  pop_op
);

    tcce_pkg::op_t                entry_reg [tcce_pkg::Q_DEPTH];
    logic [tcce_pkg::Q_AW:0]      wr_ptr_reg;
    logic [tcce_pkg::Q_AW:0]      wr_ptr_next;
    logic [tcce_pkg::Q_AW:0]      rd_ptr_reg;
    logic [tcce_pkg::Q_AW:0]      rd_ptr_next;
    logic                         full;
    logic                         empty;
    logic                         push;
    logic                         pop;

    // The extra pointer bit tells a full queue from an empty one.
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[tcce_pkg::Q_AW] != rd_ptr_reg[tcce_pkg::Q_AW]) &&
                   (wr_ptr_reg[tcce_pkg::Q_AW-1:0] == rd_ptr_reg[tcce_pkg::Q_AW-1:0]);

    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign push       = push_valid && !full;
    assign pop        = pop_ready && !empty;
    assign pop_op     = entry_reg[rd_ptr_reg[tcce_pkg::Q_AW-1:0]];

    // Advance the pointers on each transfer.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg[tcce_pkg::Q_AW-1:0]] <= push_op;
        end
    end

endmodule

FILE: hdl/tcce_back.sv
module tcce_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  tcce_pkg::op_t                   pop_op,
    input  logic [tcce_pkg::RATE_W-1:0]     blink_rate,
    output logic                            init_busy,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tcce_pkg::out_t                  out_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_BLANK,
        S_COPY,
        S_PUT,
        S_RESULT
    } state_t;

    localparam logic [tcce_pkg::ROW_W-1:0]  SCROLL_ROW_R = tcce_pkg::ROW_W'(tcce_pkg::SCROLL_ROW);
    localparam logic [tcce_pkg::COL_W-1:0]  TEXT_COLS_C  = tcce_pkg::COL_W'(tcce_pkg::TEXT_COLS);
    localparam tcce_pkg::addr_t LAST_ADDR   = tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1);
    localparam tcce_pkg::addr_t SCROLL_BASE = tcce_pkg::ADDR_W'(tcce_pkg::SCROLL_CELLS);
    localparam tcce_pkg::addr_t ROW_STEP    = tcce_pkg::ADDR_W'(tcce_pkg::STORED_COLS);

    // Cell memory and its read data register.
    logic [tcce_pkg::CELL_W-1:0] cell_mem [tcce_pkg::CELL_COUNT];
    logic [tcce_pkg::CELL_W-1:0] rd_data_reg;
    logic                        mem_we;
    tcce_pkg::addr_t             mem_waddr;
    logic [tcce_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    tcce_pkg::addr_t             mem_raddr;

    state_t                      state_reg;
    state_t                      state_next;
    state_t                      after_reg;
    state_t                      after_next;
    logic                        tail_put_reg;
    logic                        tail_put_next;
    tcce_pkg::addr_t             addr_reg;
    tcce_pkg::addr_t             addr_next;
    tcce_pkg::cnt_t              cnt_reg;
    tcce_pkg::cnt_t              cnt_next;
    logic                        copy_vld_reg;
    logic                        copy_vld_next;
    tcce_pkg::addr_t             copy_dst_reg;
    tcce_pkg::addr_t             copy_dst_next;
    logic [tcce_pkg::ROW_W-1:0]  row_reg;
    logic [tcce_pkg::ROW_W-1:0]  row_next;
    logic [tcce_pkg::COL_W-1:0]  col_reg;
    logic [tcce_pkg::COL_W-1:0]  col_next;
    tcce_pkg::op_t               cur_reg;
    tcce_pkg::op_t               cur_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    tcce_pkg::out_t              out_data_reg;
    tcce_pkg::out_t              out_data_next;

    logic                        start_nl;
    logic                        nl_put;
    tcce_pkg::cnt_t              nl_cnt;
    tcce_pkg::cnt_t              tab_end;
    tcce_pkg::cnt_t              rows_ext;
    tcce_pkg::cnt_t              rows_cl;
    logic [tcce_pkg::COL_W-1:0]  col_p4;
    logic [tcce_pkg::CELL_W-1:0] cell_out;

    assign pop_ready = (state_reg == S_IDLE);
    assign init_busy = (state_reg == S_INIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Cursor derived quantities.
    assign nl_cnt  = (tcce_pkg::CNT_W'(col_reg) < tcce_pkg::CNT_W'(tcce_pkg::TEXT_COLS)) ?
                     tcce_pkg::CNT_W'(tcce_pkg::TEXT_COLS) - tcce_pkg::CNT_W'(col_reg) : '0;
    assign tab_end = tcce_pkg::CNT_W'(col_reg) + tcce_pkg::CNT_W'(tcce_pkg::TAB_STOP);
    assign col_p4  = col_reg + tcce_pkg::COL_W'(tcce_pkg::TAB_STOP);
    assign rows_ext = tcce_pkg::CNT_W'(pop_op.clear_rows);
    assign rows_cl  = (rows_ext > tcce_pkg::CNT_W'(tcce_pkg::STORED_ROWS)) ?
                      tcce_pkg::CNT_W'(tcce_pkg::STORED_ROWS) : rows_ext;
    assign cell_out = (cur_reg.kind == tcce_pkg::OP_READ) ? rd_data_reg : '0;

    // Memory port selection by sequencer state.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = tcce_pkg::BLANK_CELL;
        mem_re    = 1'b0;
        mem_raddr = addr_reg + ROW_STEP;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
            end
            S_BLANK:
            begin
                mem_we = (cnt_reg != '0);
            end
            S_COPY:
            begin
                mem_we    = copy_vld_reg;
                mem_waddr = copy_dst_reg;
                mem_wdata = rd_data_reg;
                mem_re    = (cnt_reg != '0);
            end
            S_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = tcce_pkg::cell_addr(row_reg, col_reg);
                mem_wdata = {cur_reg.bg_color, cur_reg.fg_color, cur_reg.char_code};
            end
            S_IDLE:
            begin
                mem_re    = pop_valid && (pop_op.kind == tcce_pkg::OP_READ);
                mem_raddr = pop_op.read_addr;
            end
            S_RESULT:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        tail_put_next  = tail_put_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        copy_vld_next  = 1'b0;
        copy_dst_next  = copy_dst_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        start_nl       = 1'b0;
        nl_put         = 1'b0;

        unique case (state_reg)
            // Clearing pass over the whole store after reset.
            S_INIT:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            // Take the next operation from the queue and set up its work.
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next = pop_op;
                    unique case (pop_op.kind)
                        tcce_pkg::OP_NOP:
                        begin
                            state_next = S_RESULT;
                        end
                        tcce_pkg::OP_PUTC:
                        begin
                            if (col_reg == TEXT_COLS_C)
                            begin
                                start_nl = 1'b1;
                                nl_put   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        tcce_pkg::OP_NEWLINE:
                        begin
                            start_nl = 1'b1;
                        end
                        tcce_pkg::OP_TAB:
                        begin
                            if (tab_end >= tcce_pkg::CNT_W'(tcce_pkg::TEXT_COLS))
                            begin
                                start_nl = 1'b1;
                            end
                            else
                            begin
                                addr_next  = tcce_pkg::cell_addr(row_reg, col_reg);
                                cnt_next   = tcce_pkg::CNT_W'(tcce_pkg::TAB_STOP) -
                                             tcce_pkg::CNT_W'(col_reg[tcce_pkg::TAB_AW-1:0]);
                                col_next   = col_p4 & ~tcce_pkg::COL_W'(tcce_pkg::TAB_STOP - 1);
                                after_next = S_RESULT;
                                state_next = S_BLANK;
                            end
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            addr_next  = '0;
                            cnt_next   = rows_cl << tcce_pkg::COL_SH;
                            after_next = S_RESULT;
                            state_next = S_BLANK;
                        end
                        tcce_pkg::OP_READ:
                        begin
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            // Write blank cells over a span, then move on.
            S_BLANK:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = after_reg;
                    addr_next  = '0;
                    cnt_next   = tcce_pkg::CNT_W'(tcce_pkg::SCROLL_CELLS);
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            // Move each cell up one row; each cell is written in the cycle after its read.
            S_COPY:
            begin
                if (cnt_reg == '0)
                begin
                    addr_next  = SCROLL_BASE;
                    cnt_next   = tcce_pkg::CNT_W'(tcce_pkg::STORED_COLS);
                    after_next = tail_put_reg ? S_PUT : S_RESULT;
                    state_next = S_BLANK;
                end
                else
                begin
                    copy_vld_next = 1'b1;
                    copy_dst_next = addr_reg;
                    addr_next     = addr_reg + 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                end
            end
            // Store the character at the cursor.
            S_PUT:
            begin
                col_next   = col_reg + 1'b1;
                state_next = S_RESULT;
            end
            // Load the result register once it is free.
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.cursor_row_out = row_reg;
                    out_data_next.cursor_col_out = col_reg;
                    out_data_next.cursor_word    = {blink_rate, 8'(row_reg), 8'(col_reg)};
                    out_data_next.cell_word      = cell_out;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Newline: blank the rest of the line, then scroll or step down.
        if (start_nl)
        begin
            addr_next  = tcce_pkg::cell_addr(row_reg, col_reg);
            cnt_next   = nl_cnt;
            col_next   = '0;
            state_next = S_BLANK;
            if (row_reg == SCROLL_ROW_R)
            begin
                after_next    = S_COPY;
                tail_put_next = nl_put;
            end
            else
            begin
                row_next   = row_reg + 1'b1;
                after_next = nl_put ? S_PUT : S_RESULT;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            after_reg     <= S_RESULT;
            tail_put_reg  <= 1'b0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            copy_vld_reg  <= 1'b0;
            copy_dst_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            tail_put_reg  <= tail_put_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            copy_vld_reg  <= copy_vld_next;
            copy_dst_reg  <= copy_dst_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // The cursor stays within rows 0 to 28 and columns 0 to 80.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= SCROLL_ROW_R) && (col_reg <= TEXT_COLS_C))
        else $error("cursor outside the text area");

    // A trailing copy write only happens while the scroll is in progress.
    a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_vld_reg |-> (state_reg == S_COPY))
        else $error("copy write outside the scroll sequence");

    // Taking an operation always starts its work.
    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && (state_reg == S_IDLE)) |=> (state_reg != S_IDLE))
        else $error("operation taken but sequencer stayed idle");

endmodule

FILE: hdl/text_console_cursor_engine.sv
// Text console engine with a 32 x 128 cell store (30 x 80 visible text area)
// and one cursor. Each request yields exactly one result that reports the
// cursor after the request, plus the cell contents for a read. Requests pass
// through a front stage and a four-entry queue, so the request side keeps
// flowing while the cell sequencer works; all cell work runs through a single
// memory with one write and one read port, one cell per cycle. Work per
// request at the sequencer: an ignored character or a read goes straight
// to the result, a printable character writes one cell, a tab blanks up to
// the next tab stop, a newline blanks the rest of the line, and a newline on
// row 28 also moves the rows up and blanks row 28. A clear of N rows blanks
// N x 128 cells. After reset the block blanks all 4096 cells, one per cycle,
// holding in_stall high meanwhile; the configuration port is always ready.
module text_console_cursor_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tcce_pkg::in_t                in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tcce_pkg::out_t               out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tcce_pkg::RATE_W-1:0]  cfg_data
);

    logic [tcce_pkg::RATE_W-1:0] blink_rate_reg;
    logic [tcce_pkg::RATE_W-1:0] blink_rate_next;
    logic                        init_busy;
    logic                        push_valid;
    logic                        push_ready;
    tcce_pkg::op_t               push_op;
    logic                        pop_valid;
    logic                        pop_ready;
    tcce_pkg::op_t               pop_op;

    // Blink rate register, written from the configuration channel.
    assign cfg_ready       = 1'b1;
    assign blink_rate_next = (cfg_valid && cfg_ready) ? cfg_data : blink_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_rate_reg <= tcce_pkg::RATE_W'(31);
        end
        else
        begin
            blink_rate_reg <= blink_rate_next;
        end
    end

    // Front: accepts and classifies requests.
    tcce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .init_busy  (init_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Queue between front and back.
    tcce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back: cell sequencer, cursor and result register.
    tcce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .blink_rate (blink_rate_reg),
        .init_busy  (init_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
